// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each assumes signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define EMM_ASSERT_IMPL(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("assertion failed");

// Next-cycle implication.
`define EMM_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/emm_pkg.sv -----
package emm_pkg;

   localparam int HANDLES = 64;
   localparam int FRAMES = 4;
   localparam int HANDLE_W = (HANDLES > 1) ? $clog2(HANDLES) : 1;
   localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = (HANDLE_W > FRAME_W) ? HANDLE_W : FRAME_W;
   localparam int FH_W = HANDLE_W + 1;
   localparam int HIU_W = $clog2(HANDLES + 1);
   localparam int SAVE_DEPTH = HANDLES * FRAMES;
   localparam int SAVE_AW = (SAVE_DEPTH > 1) ? $clog2(SAVE_DEPTH) : 1;

   localparam logic [FH_W-1:0] FH_NONE = '1;
   localparam logic [15:0] NPAGE = 16'hFFFF;
   localparam logic [15:0] VERSION = 16'h0032;
   localparam logic [15:0] MAP_SIZE = 16'd32;
   localparam logic [8:0] EH_NONE = 9'h1FF;
   localparam logic [15:0] TOTAL_PAGES_RST = 16'd64;
   localparam logic [15:0] FRAME_SEG_RST = 16'hD000;

   localparam logic [4:0] CMD_STATUS = 5'd0;
   localparam logic [4:0] CMD_SEGMENT = 5'd1;
   localparam logic [4:0] CMD_PAGES = 5'd2;
   localparam logic [4:0] CMD_ALLOC = 5'd3;
   localparam logic [4:0] CMD_MAP = 5'd4;
   localparam logic [4:0] CMD_FREE = 5'd5;
   localparam logic [4:0] CMD_VERSION = 5'd6;
   localparam logic [4:0] CMD_SAVE = 5'd7;
   localparam logic [4:0] CMD_RESTORE = 5'd8;
   localparam logic [4:0] CMD_HCOUNT = 5'd9;
   localparam logic [4:0] CMD_OWNED = 5'd10;
   localparam logic [4:0] CMD_LIST = 5'd11;
   localparam logic [4:0] CMD_RD_FRAMES = 5'd12;
   localparam logic [4:0] CMD_SET_FRAME = 5'd13;
   localparam logic [4:0] CMD_XCHG_FRAME = 5'd14;
   localparam logic [4:0] CMD_MAP_SIZE = 5'd15;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BAD_HANDLE = 3'd1;
   localparam logic [2:0] ST_UNSUP = 3'd2;
   localparam logic [2:0] ST_NO_HANDLES = 3'd3;
   localparam logic [2:0] ST_NO_PAGES = 3'd4;
   localparam logic [2:0] ST_ZERO_PAGES = 3'd5;
   localparam logic [2:0] ST_PAGE_RANGE = 3'd6;
   localparam logic [2:0] ST_BAD_FRAME = 3'd7;

   localparam logic REG_TOTAL_PAGES = 1'b0;
   localparam logic REG_FRAME_SEGMENT = 1'b1;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LATCH,
      OP_LOOK,
      OP_EXEC,
      OP_FILL,
      OP_RREAD,
      OP_RAPPLY,
      OP_FOUT,
      OP_LSCAN,
      OP_LOUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } emm_cmd_type;

   typedef struct packed {
      logic [4:0] cmd;
      logic ok;
      logic cnt_end;
      logic scan_hit;
      logic list_last;
      logic none_used;
   } emm_sts_type;

endpackage

// ----- rtl/core/emm_ram.sv -----
module emm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/emm_ctrl.sv -----
module emm_ctrl import emm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  emm_sts_type sts,
   output emm_cmd_type cmd,
   output logic busy
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_LOOK   = 9'b000000010,
      S_EXEC   = 9'b000000100,
      S_FILL   = 9'b000001000,
      S_RREAD  = 9'b000010000,
      S_RAPPLY = 9'b000100000,
      S_FOUT   = 9'b001000000,
      S_LSCAN  = 9'b010000000,
      S_LOUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = OP_LATCH;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.op = OP_LOOK;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.op = OP_EXEC;
            state_in = S_IDLE;
            case (sts.cmd)
               CMD_ALLOC, CMD_SAVE: begin
                  if (sts.ok) state_in = S_FILL;
               end
               CMD_RESTORE: begin
                  if (sts.ok) state_in = S_RREAD;
               end
               CMD_RD_FRAMES, CMD_XCHG_FRAME: state_in = S_FOUT;
               CMD_LIST: begin
                  if (!sts.none_used) state_in = S_LSCAN;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_FILL: begin
            cmd.op = OP_FILL;
            if (sts.cnt_end) state_in = S_IDLE;
         end
         S_RREAD: begin
            cmd.op = OP_RREAD;
            state_in = S_RAPPLY;
         end
         S_RAPPLY: begin
            cmd.op = OP_RAPPLY;
            state_in = sts.cnt_end ? S_IDLE : S_RREAD;
         end
         S_FOUT: begin
            cmd.op = OP_FOUT;
            if (sts.cnt_end) state_in = S_IDLE;
         end
         S_LSCAN: begin
            cmd.op = OP_LSCAN;
            if (sts.scan_hit) state_in = S_LOUT;
         end
         S_LOUT: begin
            cmd.op = OP_LOUT;
            state_in = sts.list_last ? S_IDLE : S_LSCAN;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- rtl/core/emm_dp.sv -----
module emm_dp import emm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  emm_cmd_type cmd,
   output emm_sts_type sts,
   input  logic [4:0] req_cmd,
   input  logic [15:0] req_handle,
   input  logic [7:0] req_frame,
   input  logic [15:0] req_logical_page,
   input  logic [15:0] req_page_count,
   input  logic signed [8:0] req_set_handle,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [15:0] csr_wdata,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_word_a,
   output logic [15:0] rsp_word_b,
   output logic signed [8:0] rsp_entry_handle,
   output logic [15:0] rsp_entry_page,
   output logic rsp_last
);

   logic [4:0] cmd_ff, cmd_in;
   logic [15:0] h_ff, h_in;
   logic [7:0] f_ff, f_in;
   logic [15:0] lp_ff, lp_in;
   logic [15:0] pc_ff, pc_in;
   logic [8:0] sh_ff, sh_in;
   logic [HANDLE_W-1:0] tgt_ff, tgt_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0] st_ff, st_in;
   logic pend_wr_ff, pend_wr_in;
   logic pend_clr_ff, pend_clr_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] seg_ff, seg_in;
   logic [HANDLES-1:0] valid_ff, valid_in;
   logic [FH_W-1:0] fh_ff [FRAMES];
   logic [FH_W-1:0] fh_in [FRAMES];
   logic [15:0] fp_ff [FRAMES];
   logic [15:0] fp_in [FRAMES];
   logic [HIU_W-1:0] hiu_ff, hiu_in;
   logic [15:0] piu_ff, piu_in;

   logic out_valid_ff, out_valid_in;
   logic [2:0] out_st_ff, out_st_in;
   logic [15:0] out_a_ff, out_a_in;
   logic [15:0] out_b_ff, out_b_in;
   logic [8:0] out_eh_ff, out_eh_in;
   logic [15:0] out_ep_ff, out_ep_in;
   logic out_last_ff, out_last_in;

   logic hpc_we;
   logic [HANDLE_W-1:0] hpc_waddr, hpc_raddr;
   logic [15:0] hpc_rd;
   logic sv_we;
   logic [SAVE_AW-1:0] sv_waddr, sv_raddr;
   logic [15:0] sv_wdata, sv_rd;

   logic [HANDLE_W-1:0] hidx, shidx, cidx, free_idx;
   logic [FRAME_W-1:0] fidx, cfr;
   logic [FH_W-1:0] hcmp, shcmp;
   logic h_ok, sh_ok, frame_ok, any_free, more_above, ok;
   logic [15:0] free_pages;
   logic [2:0] set_st;
   logic set_wr, set_clr;

   emm_ram #(.WIDTH(16), .DEPTH(HANDLES)) u_hpc_ram (
      .clock   (clock),
      .wr_en   (hpc_we),
      .wr_addr (hpc_waddr),
      .wr_data (pc_ff),
      .rd_addr (hpc_raddr),
      .rd_data (hpc_rd)
   );

   emm_ram #(.WIDTH(16), .DEPTH(SAVE_DEPTH)) u_save_ram (
      .clock   (clock),
      .wr_en   (sv_we),
      .wr_addr (sv_waddr),
      .wr_data (sv_wdata),
      .rd_addr (sv_raddr),
      .rd_data (sv_rd)
   );

   assign hidx = h_ff[HANDLE_W-1:0];
   assign shidx = sh_ff[HANDLE_W-1:0];
   assign cidx = cnt_ff[HANDLE_W-1:0];
   assign fidx = f_ff[FRAME_W-1:0];
   assign cfr = cnt_ff[FRAME_W-1:0];
   assign hcmp = {1'b0, hidx};
   assign shcmp = {1'b0, shidx};

   assign h_ok = (h_ff < 16'(HANDLES)) && valid_ff[hidx];
   assign sh_ok = (sh_ff < 9'(HANDLES)) && valid_ff[shidx];
   assign frame_ok = (f_ff < 8'(FRAMES));
   assign free_pages = (total_ff >= piu_ff) ? (total_ff - piu_ff) : 16'd0;

   assign hpc_raddr = ((cmd.op == OP_LSCAN) || (cmd.op == OP_LOUT)) ? cidx :
                      ((cmd_ff == CMD_SET_FRAME) || (cmd_ff == CMD_XCHG_FRAME)) ? shidx : hidx;
   assign hpc_waddr = free_idx;
   assign sv_raddr = SAVE_AW'(hidx) * SAVE_AW'(FRAMES) + SAVE_AW'(cfr);
   assign sv_waddr = SAVE_AW'(tgt_ff) * SAVE_AW'(FRAMES) + SAVE_AW'(cfr);

   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = HANDLES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = HANDLE_W'(i);
            any_free = 1'b1;
         end
      end
   end

   always_comb begin
      more_above = 1'b0;
      for (int i = 0; i < HANDLES; i++) begin
         if (valid_ff[i] && (HANDLE_W'(i) > cidx)) more_above = 1'b1;
      end
   end

   always_comb begin
      set_st = ST_OK;
      set_wr = 1'b0;
      set_clr = 1'b0;
      if (!frame_ok) begin
         set_st = ST_BAD_FRAME;
      end else if (sh_ff == EH_NONE) begin
         set_clr = 1'b1;
      end else if (!sh_ok) begin
         set_st = ST_BAD_HANDLE;
      end else if (lp_ff == NPAGE) begin
         set_clr = 1'b1;
      end else if (lp_ff >= hpc_rd) begin
         set_st = ST_PAGE_RANGE;
      end else begin
         set_wr = 1'b1;
      end
   end

   always_comb begin
      cmd_in = cmd_ff;
      h_in = h_ff;
      f_in = f_ff;
      lp_in = lp_ff;
      pc_in = pc_ff;
      sh_in = sh_ff;
      tgt_in = tgt_ff;
      cnt_in = cnt_ff;
      st_in = st_ff;
      pend_wr_in = pend_wr_ff;
      pend_clr_in = pend_clr_ff;
      total_in = total_ff;
      seg_in = seg_ff;
      valid_in = valid_ff;
      fh_in = fh_ff;
      fp_in = fp_ff;
      hiu_in = hiu_ff;
      piu_in = piu_ff;
      hpc_we = 1'b0;
      sv_we = 1'b0;
      sv_wdata = NPAGE;
      ok = 1'b0;
      out_valid_in = 1'b0;
      out_st_in = ST_OK;
      out_a_in = '0;
      out_b_in = '0;
      out_eh_in = '0;
      out_ep_in = '0;
      out_last_in = 1'b1;

      if (csr_write) begin
         case (csr_index)
            REG_TOTAL_PAGES: total_in = csr_wdata;
            REG_FRAME_SEGMENT: seg_in = csr_wdata;
            default: total_in = total_ff;
         endcase
      end

      case (cmd.op)
         OP_LATCH: begin
            cmd_in = req_cmd;
            h_in = req_handle;
            f_in = req_frame;
            lp_in = req_logical_page;
            pc_in = req_page_count;
            sh_in = req_set_handle;
            cnt_in = '0;
         end
         OP_EXEC: begin
            out_valid_in = 1'b1;
            cnt_in = '0;
            tgt_in = hidx;
            case (cmd_ff)
               CMD_STATUS: out_st_in = ST_OK;
               CMD_SEGMENT: out_a_in = seg_ff;
               CMD_PAGES: begin
                  out_a_in = free_pages;
                  out_b_in = total_ff;
               end
               CMD_ALLOC: begin
                  if (pc_ff == 16'd0) begin
                     out_st_in = ST_ZERO_PAGES;
                  end else if (hiu_ff >= HIU_W'(HANDLES)) begin
                     out_st_in = ST_NO_HANDLES;
                  end else if (pc_ff > free_pages) begin
                     out_st_in = ST_NO_PAGES;
                  end else if (!any_free) begin
                     out_st_in = ST_NO_HANDLES;
                  end else begin
                     ok = 1'b1;
                     out_b_in = 16'(free_idx);
                     tgt_in = free_idx;
                     valid_in[free_idx] = 1'b1;
                     hiu_in = hiu_ff + HIU_W'(1);
                     piu_in = piu_ff + pc_ff;
                     hpc_we = 1'b1;
                  end
               end
               CMD_MAP: begin
                  if (!h_ok) begin
                     out_st_in = ST_BAD_HANDLE;
                  end else if (!frame_ok) begin
                     out_st_in = ST_BAD_FRAME;
                  end else if (lp_ff == NPAGE) begin
                     fh_in[fidx] = FH_NONE;
                     fp_in[fidx] = NPAGE;
                  end else if (lp_ff >= hpc_rd) begin
                     out_st_in = ST_PAGE_RANGE;
                  end else begin
                     fh_in[fidx] = hcmp;
                     fp_in[fidx] = lp_ff;
                  end
               end
               CMD_FREE: begin
                  if (!h_ok) begin
                     out_st_in = ST_BAD_HANDLE;
                  end else begin
                     for (int i = 0; i < FRAMES; i++) begin
                        if (fh_ff[i] == hcmp) fh_in[i] = FH_NONE;
                     end
                     piu_in = piu_ff - hpc_rd;
                     valid_in[hidx] = 1'b0;
                     hiu_in = hiu_ff - HIU_W'(1);
                  end
               end
               CMD_VERSION: out_a_in = VERSION;
               CMD_SAVE, CMD_RESTORE: begin
                  if (!h_ok) out_st_in = ST_BAD_HANDLE;
                  else ok = 1'b1;
               end
               CMD_HCOUNT: out_a_in = 16'(hiu_ff);
               CMD_OWNED: begin
                  if (!h_ok) out_st_in = ST_BAD_HANDLE;
                  else out_a_in = hpc_rd;
               end
               CMD_LIST: begin
                  if (hiu_ff == '0) out_eh_in = EH_NONE;
                  else out_valid_in = 1'b0;
               end
               CMD_RD_FRAMES: begin
                  out_valid_in = 1'b0;
                  st_in = ST_OK;
                  pend_wr_in = 1'b0;
                  pend_clr_in = 1'b0;
               end
               CMD_SET_FRAME: begin
                  out_st_in = set_st;
                  if (set_clr) begin
                     fh_in[fidx] = FH_NONE;
                     fp_in[fidx] = NPAGE;
                  end else if (set_wr) begin
                     fh_in[fidx] = shcmp;
                     fp_in[fidx] = lp_ff;
                  end
               end
               CMD_XCHG_FRAME: begin
                  out_valid_in = 1'b0;
                  st_in = set_st;
                  pend_wr_in = set_wr;
                  pend_clr_in = set_clr;
               end
               CMD_MAP_SIZE: out_a_in = MAP_SIZE;
               default: out_st_in = ST_UNSUP;
            endcase
         end
         OP_FILL: begin
            sv_we = 1'b1;
            if ((cmd_ff == CMD_SAVE) && (fh_ff[cfr] == hcmp)) sv_wdata = fp_ff[cfr];
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_RAPPLY: begin
            if (sv_rd != NPAGE) begin
               fh_in[cfr] = hcmp;
               fp_in[cfr] = sv_rd;
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_FOUT: begin
            out_valid_in = 1'b1;
            out_st_in = st_ff;
            out_eh_in = (fh_ff[cfr] == FH_NONE) ? EH_NONE : 9'(fh_ff[cfr]);
            out_ep_in = fp_ff[cfr];
            out_last_in = sts.cnt_end;
            if (sts.cnt_end) begin
               if (pend_clr_ff) begin
                  fh_in[fidx] = FH_NONE;
                  fp_in[fidx] = NPAGE;
               end else if (pend_wr_ff) begin
                  fh_in[fidx] = shcmp;
                  fp_in[fidx] = lp_ff;
               end
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_LSCAN: begin
            if (!valid_ff[cidx]) cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_LOUT: begin
            out_valid_in = 1'b1;
            out_a_in = 16'(hiu_ff);
            out_eh_in = 9'(cidx);
            out_ep_in = hpc_rd;
            out_last_in = !more_above;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_PAGES_RST;
         seg_ff <= FRAME_SEG_RST;
         valid_ff <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            fh_ff[i] <= FH_NONE;
            fp_ff[i] <= '0;
         end
         hiu_ff <= '0;
         piu_ff <= '0;
         cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         seg_ff <= seg_in;
         valid_ff <= valid_in;
         fh_ff <= fh_in;
         fp_ff <= fp_in;
         hiu_ff <= hiu_in;
         piu_ff <= piu_in;
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      h_ff <= h_in;
      f_ff <= f_in;
      lp_ff <= lp_in;
      pc_ff <= pc_in;
      sh_ff <= sh_in;
      tgt_ff <= tgt_in;
      st_ff <= st_in;
      pend_wr_ff <= pend_wr_in;
      pend_clr_ff <= pend_clr_in;
      out_st_ff <= out_st_in;
      out_a_ff <= out_a_in;
      out_b_ff <= out_b_in;
      out_eh_ff <= out_eh_in;
      out_ep_ff <= out_ep_in;
      out_last_ff <= out_last_in;
   end

   assign sts.cmd = cmd_ff;
   assign sts.ok = ok;
   assign sts.cnt_end = (cnt_ff == CNT_W'(FRAMES - 1));
   assign sts.scan_hit = valid_ff[cidx];
   assign sts.list_last = !more_above;
   assign sts.none_used = (hiu_ff == '0);

   assign rsp_valid = out_valid_ff;
   assign rsp_status = out_st_ff;
   assign rsp_word_a = out_a_ff;
   assign rsp_word_b = out_b_ff;
   assign rsp_entry_handle = out_eh_ff;
   assign rsp_entry_page = out_ep_ff;
   assign rsp_last = out_last_ff;

endmodule

// ----- rtl/core/expanded_memory_page_mapper_unit.sv -----
// A single-result item passes through the latch, look and execute states to a registered result.
// The unit takes one item at a time, accepting a new one only while idle. Allocate
// and save make one save-memory write per frame, restore reads and applies per frame,
// frame reads give one result per frame, and the handle list scans each table entry.
// Reset clears the handle valid bits, frames and counters and loads the configuration
// defaults; there is no memory clearing pass. Results cannot be stalled.
`include "assert_macros.svh"

module expanded_memory_page_mapper_unit import emm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [4:0] req_cmd,
   input  logic [15:0] req_handle,
   input  logic [7:0] req_frame,
   input  logic [15:0] req_logical_page,
   input  logic [15:0] req_page_count,
   input  logic signed [8:0] req_set_handle,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_word_a,
   output logic [15:0] rsp_word_b,
   output logic signed [8:0] rsp_entry_handle,
   output logic [15:0] rsp_entry_page,
   output logic rsp_last,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [15:0] csr_wdata
);

   emm_cmd_type cmd;
   emm_sts_type sts;

   assign csr_ready = 1'b1;

   emm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   emm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_cmd          (req_cmd),
      .req_handle       (req_handle),
      .req_frame        (req_frame),
      .req_logical_page (req_logical_page),
      .req_page_count   (req_page_count),
      .req_set_handle   (req_set_handle),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_word_a       (rsp_word_a),
      .rsp_word_b       (rsp_word_b),
      .rsp_entry_handle (rsp_entry_handle),
      .rsp_entry_page   (rsp_entry_page),
      .rsp_last         (rsp_last)
   );

   `EMM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `EMM_ASSERT_IMPL(a_more_busy, rsp_valid && !rsp_last, busy)
   `EMM_ASSERT_IMPL(a_unsup_single, rsp_valid && (rsp_status == ST_UNSUP), rsp_last)

endmodule
